[rtl/lf_pkg.sv]
// Package for the line framer: operation and result codes, the command passed
// from the front end to the back end, and the back-end state type.
// No dependencies.
`default_nettype none
package lf_pkg;

	localparam int LEN_W = 6;

	localparam logic [1:0] OP_BYTE    = 2'd0;
	localparam logic [1:0] OP_POLL    = 2'd1;
	localparam logic [1:0] OP_LINKERR = 2'd2;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam logic [1:0] REG_TIMEOUT  = 2'd0;
	localparam logic [1:0] REG_CAPACITY = 2'd1;

	localparam logic [15:0] CAPACITY_RESET = 16'd64;

	typedef enum logic [2:0] {
		KIND_BYTE     = 3'd0,
		KIND_EMPTY    = 3'd1,
		KIND_OVERFLOW = 3'd2,
		KIND_CAPACITY = 3'd3,
		KIND_TIMEOUT  = 3'd4,
		KIND_LINKERR  = 3'd5
	} kind_t;

	// KIND_BYTE in a command means: read out len bytes from the line store
	typedef struct packed {
		kind_t              kind;
		logic [LEN_W-1:0]   len;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_FETCH
	} bk_state_t;

endpackage
`default_nettype wire

[rtl/lf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none
module lf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/lf_fifo.sv]
// Two-entry command queue between the front end and the back end.
// Depends on lf_pkg.
`default_nettype none
module lf_fifo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire lf_pkg::cmd_t push_cmd,
	input  wire logic         pop,
	output lf_pkg::cmd_t      head,
	output logic              full,
	output logic              empty
);
	import lf_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/lf_front.sv]
// Front end: accepts input items, keeps the partial line in the line store
// and queues one command per reported event. Depends on lf_pkg.
`default_nettype none
module lf_front #(
	parameter int LINE_BYTES = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    op,
	input  wire logic [7:0]                    data_byte,
	input  wire logic [31:0]                   now_ms,
	input  wire logic [31:0]                   idle_limit,
	input  wire logic [15:0]                   out_capacity,
	input  wire logic                          q_full,
	output logic                               q_push,
	output lf_pkg::cmd_t                       q_cmd,
	input  wire logic                          line_done,
	output logic                               ram_we,
	output logic [$clog2(LINE_BYTES)-1:0]      ram_waddr,
	output logic [7:0]                         ram_wdata
);
	import lf_pkg::*;

	localparam int LW = $clog2(LINE_BYTES);

	logic [LW-1:0] stored_length_q;
	logic [31:0]   start_time_q;
	logic          line_pend_q;   // a line readout is queued or running

	logic          accept;
	logic [LW-1:0] len_d;
	logic          len_zero;
	logic          too_long;
	logic          timed_out;
	logic [31:0]   age;

	// store entries are being read back while a line is pending
	assign in_ready  = !q_full && !line_pend_q;
	assign accept    = in_valid && in_ready;
	assign len_zero  = (stored_length_q == '0);
	assign too_long  = ((17'(stored_length_q) + 17'd1) > 17'(out_capacity));
	assign age       = now_ms - start_time_q;
	assign timed_out = (idle_limit != 32'd0) && !len_zero && (age >= idle_limit);

	assign ram_waddr = stored_length_q;
	assign ram_wdata = data_byte;

	always_comb begin
		q_push     = 1'b0;
		q_cmd.kind = KIND_LINKERR;
		q_cmd.len  = '0;
		ram_we     = 1'b0;
		len_d      = stored_length_q;
		if (accept) begin
			case (op)
				OP_LINKERR: begin
					q_push = 1'b1;
					len_d  = '0;
				end
				OP_POLL: begin
					if (timed_out) begin
						q_push     = 1'b1;
						q_cmd.kind = KIND_TIMEOUT;
						len_d      = '0;
					end
				end
				OP_BYTE: begin
					if (data_byte == CHAR_LF) begin
						q_push = 1'b1;
						len_d  = '0;
						if (too_long) begin
							q_cmd.kind = KIND_CAPACITY;
						end else if (len_zero) begin
							q_cmd.kind = KIND_EMPTY;
						end else begin
							q_cmd.kind = KIND_BYTE;
							q_cmd.len  = LEN_W'(stored_length_q);
						end
					end else if (data_byte != CHAR_CR) begin
						if (stored_length_q == LW'(LINE_BYTES - 1)) begin
							q_push     = 1'b1;
							q_cmd.kind = KIND_OVERFLOW;
							len_d      = '0;
						end else begin
							ram_we = 1'b1;
							len_d  = stored_length_q + LW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_length_q <= '0;
			start_time_q    <= 32'd0;
			line_pend_q     <= 1'b0;
		end else begin
			stored_length_q <= len_d;
			if (accept && op == OP_BYTE && len_zero) begin
				start_time_q <= now_ms;
			end
			if (q_push && q_cmd.kind == KIND_BYTE) begin
				line_pend_q <= 1'b1;
			end else if (line_done) begin
				line_pend_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/lf_back.sv]
// Back end: takes commands from the queue and drives the result register,
// reading a completed line out of the line store. Depends on lf_pkg.
`default_nettype none
module lf_back #(
	parameter int LINE_BYTES = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lf_pkg::cmd_t              q_head,
	input  wire logic                      q_empty,
	output logic                           q_pop,
	output logic                           line_done,
	output logic                           ram_re,
	output logic [$clog2(LINE_BYTES)-1:0]  ram_raddr,
	input  wire logic [7:0]                ram_rdata,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output lf_pkg::kind_t                  out_kind,
	output logic [7:0]                     out_byte,
	output logic                           out_last,
	output logic [lf_pkg::LEN_W-1:0]       out_length
);
	import lf_pkg::*;

	localparam int LW = $clog2(LINE_BYTES);

	bk_state_t        state_q, state_d;
	logic [LW-1:0]    idx_q, idx_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             out_free;
	logic             load;
	logic             fetch_last;
	kind_t            kind_d;
	logic [7:0]       byte_d;
	logic             last_d;
	logic [LEN_W-1:0] length_d;

	assign out_free   = !out_valid || out_ready;
	assign fetch_last = ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		len_d     = len_q;
		q_pop     = 1'b0;
		line_done = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		load      = 1'b0;
		kind_d    = q_head.kind;
		byte_d    = 8'd0;
		last_d    = 1'b1;
		length_d  = '0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop = 1'b1;
					if (q_head.kind == KIND_BYTE) begin
						ram_re  = 1'b1;
						idx_d   = '0;
						len_d   = q_head.len;
						state_d = BK_FETCH;
					end else begin
						load = 1'b1;
					end
				end
			end
			BK_FETCH: begin
				// read data holds until the next read request
				if (out_free) begin
					load     = 1'b1;
					kind_d   = KIND_BYTE;
					byte_d   = ram_rdata;
					last_d   = fetch_last;
					length_d = len_q;
					if (fetch_last) begin
						line_done = 1'b1;
						state_d   = BK_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = idx_q + LW'(1);
						idx_d     = idx_q + LW'(1);
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		len_q <= len_d;
		if (load) begin
			out_kind   <= kind_d;
			out_byte   <= byte_d;
			out_last   <= last_d;
			out_length <= length_d;
		end
	end

endmodule
`default_nettype wire

[rtl/line_framer_with_timeout.sv]
// Line framer: assembles received bytes into lines and reports line events.
// Depends on lf_pkg, lf_ram, lf_fifo, lf_front and lf_back.
//
// Input stream s_*: one item per request, s_tuser = op (0 byte, 1 poll,
// 2 link error), s_tdata = data byte and current time in ms.
// Output stream m_*: m_tuser = result kind, m_tdata = line byte and line
// length, m_tlast marks the final result of one input item.
// APB port: register 0 at 0x0 is the idle timeout in ms (0 disables),
// register 1 at 0x4 is out_capacity. pready is tied high.
// Throughput: one input item per cycle while the command queue is not full and no line readout is pending.
// A line feed that completes an N-byte line holds s_tready low until the
// back end has read all N bytes from the line store, one per cycle while
// m_tready is high (one store read port). A single result passes the command
// queue and the output register; a line byte also passes the store read.
// A two-entry command queue lets the input side run on while the receiver
// stalls; when it fills, s_tready drops. Results already in the output
// register hold until taken.
// Reset clears the partial line, the start time, the queue and the output
// valid, and restores the timeout to 0 and out_capacity to 64.
`default_nettype none
module line_framer_with_timeout #(
	parameter int LINE_BYTES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] now_ms
	input  wire logic [1:0]  s_tuser,   // [1:0] op
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // [7:0] line_byte, [13:8] line_length, [15:14] zero
	output logic      [2:0]  m_tuser,   // [2:0] kind
	output logic             m_tlast
);
	import lf_pkg::*;

	localparam int LW = $clog2(LINE_BYTES);

	logic [31:0] timeout_q;
	logic [15:0] capacity_q;
	logic        cfg_we;
	logic [1:0]  cfg_idx;

	cmd_t             push_cmd, head;
	logic             push, pop, full, empty;
	logic             line_done;
	logic             ram_we, ram_re;
	logic [LW-1:0]    ram_waddr, ram_raddr;
	logic [7:0]       ram_wdata, ram_rdata;
	kind_t            out_kind;
	logic [7:0]       out_byte;
	logic [LEN_W-1:0] out_length;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = {1'b0, paddr[2]};

	always_comb begin
		case (cfg_idx)
			REG_TIMEOUT:  prdata = timeout_q;
			REG_CAPACITY: prdata = {16'd0, capacity_q};
			default:      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= 32'd0;
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TIMEOUT:  timeout_q  <= pwdata;
				REG_CAPACITY: capacity_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	lf_front #(.LINE_BYTES(LINE_BYTES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.op           (s_tuser),
		.data_byte    (s_tdata[7:0]),
		.now_ms       (s_tdata[39:8]),
		.idle_limit   (timeout_q),
		.out_capacity (capacity_q),
		.q_full       (full),
		.q_push       (push),
		.q_cmd        (push_cmd),
		.line_done    (line_done),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata)
	);

	lf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	lf_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lf_back #(.LINE_BYTES(LINE_BYTES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_head     (head),
		.q_empty    (empty),
		.q_pop      (pop),
		.line_done  (line_done),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.out_last   (m_tlast),
		.out_length (out_length)
	);

	assign m_tuser = out_kind;
	assign m_tdata = {2'b00, out_length, out_byte};

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for line_framer_with_timeout: directed and random byte, poll and
// link-error requests, checked against an in-bench line framing predictor.
// Depends on lf_pkg and the line_framer_with_timeout RTL.
module tb_top;
	import lf_pkg::*;

	localparam int LINE_BYTES = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [2:0] ADDR_TIMEOUT = 3'(4 * REG_TIMEOUT);
	localparam logic [2:0] ADDR_CAPACITY = 3'(4 * REG_CAPACITY);
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 120;
	localparam int PHASES = 4;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data;
		logic             last;
		logic [LEN_W-1:0] len;
	} line_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // [7:0] data_byte, [39:8] now_ms
	logic [1:0]  s_tuser = '0;   // [1:0] op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [7:0] line_byte, [13:8] line_length, [15:14] zero
	logic [2:0]  m_tuser;        // [2:0] kind
	logic        m_tlast;

	line_framer_with_timeout #(.LINE_BYTES(LINE_BYTES)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #6 clk = ~clk;

	// predictor state and configuration
	logic [7:0]   line_copy [LINE_BYTES];
	logic [6:0]   line_fill = '0;
	logic [31:0]  line_t0 = '0;
	logic [31:0]  cfg_timeout = '0;
	logic [15:0]  cfg_capacity = CAPACITY_RESET;
	line_result_t pending_results[$];

	logic [31:0] clock_ms = '0;
	bit          calm = 1'b0;   // no idling on either side while set
	int          n_bad = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          rx_seen = 0;
	int          rx_wait = 0;

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			n_bad++;
			$display("%0t %s mismatch: expected %0h, got %0h", $time, what, want, got);
		end
	endfunction

	function automatic void push_result(kind_t k, logic [7:0] d, logic l, logic [LEN_W-1:0] n);
		line_result_t r;
		r.kind = k;
		r.data = d;
		r.last = l;
		r.len = n;
		pending_results.push_back(r);
	endfunction

	function automatic void frame_item(logic [1:0] op, logic [7:0] b, logic [31:0] now);
		logic [31:0] elapsed;
		int n;
		elapsed = now - line_t0;
		case (op)
			OP_LINKERR: begin
				line_fill = '0;
				push_result(KIND_LINKERR, '0, 1'b1, '0);
			end
			OP_POLL: begin
				if (cfg_timeout != 0 && line_fill != 0 && elapsed >= cfg_timeout) begin
					line_fill = '0;
					push_result(KIND_TIMEOUT, '0, 1'b1, '0);
				end
			end
			OP_BYTE: begin
				if (line_fill == 0)
					line_t0 = now;
				if (b == CHAR_LF) begin
					n = line_fill;
					line_fill = '0;
					if (n + 1 > cfg_capacity)
						push_result(KIND_CAPACITY, '0, 1'b1, '0);
					else if (n == 0)
						push_result(KIND_EMPTY, '0, 1'b1, '0);
					else
						for (int i = 0; i < n; i++)
							push_result(KIND_BYTE, line_copy[i], i == n - 1, LEN_W'(n));
				end else if (b != CHAR_CR) begin
					if (line_fill + 1 >= LINE_BYTES) begin
						line_fill = '0;
						push_result(KIND_OVERFLOW, '0, 1'b1, '0);
					end else begin
						line_copy[line_fill] = b;
						line_fill++;
					end
				end
			end
			default: ;   // unused op: no result, no state change
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin : take_result
		line_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				n_bad++;
				$display("%0t unexpected result: expected none, got kind %0d data %0h last %0b",
					$time, m_tuser, m_tdata, m_tlast);
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, m_tuser);
				check_field("line_byte", want.data, m_tdata[7:0]);
				check_field("last", want.last, m_tlast);
				check_field("line_length", want.len, m_tdata[13:8]);
				check_field("pad", '0, m_tdata[15:14]);
			end
		end
	end

	// receiver stalls: a fresh wait after each result, plus the odd spontaneous one
	always @(negedge clk) begin
		if (rx_seen != results_seen) begin
			rx_seen = results_seen;
			rx_wait = calm ? 0 : $urandom_range(0, 6);
		end else if (rx_wait == 0 && !calm && $urandom_range(0, 9) == 0) begin
			rx_wait = $urandom_range(1, 6);
		end
		if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [7:0] b);
		int gap;
		logic [31:0] now;
		gap = calm ? 0 : $urandom_range(0, 6);
		now = clock_ms;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {now, b};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		frame_item(op, b, now);
		items_sent++;
	endtask

	// bytes that are neither CR nor LF
	task automatic send_filler(input int n);
		for (int i = 0; i < n; i++)
			send_item(OP_BYTE, 8'($urandom_range(16, 255)));
	endtask

	task automatic settle_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_register(input logic [2:0] addr);
		logic [31:0] rd;
		apb_access(1'b0, addr, '0, rd);
		check_field($sformatf("register %0h", addr),
			addr == ADDR_TIMEOUT ? cfg_timeout : {16'h0, cfg_capacity}, rd);
	endtask

	task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
		logic [31:0] rd;
		apb_access(1'b1, addr, value, rd);
		if (addr == ADDR_TIMEOUT)
			cfg_timeout = value;
		else if (addr == ADDR_CAPACITY)
			cfg_capacity = value[15:0];
		check_register(addr);
	endtask

	task automatic test_register_defaults();
		check_register(ADDR_TIMEOUT);
		check_register(ADDR_CAPACITY);
	endtask

	task automatic test_line_basics();
		send_item(OP_BYTE, CHAR_LF);            // empty line
		send_item(OP_BYTE, CHAR_CR);
		send_item(OP_BYTE, CHAR_LF);            // CR alone is dropped
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, CHAR_CR);
		send_item(OP_BYTE, 8'h55);
		send_item(OP_BYTE, 8'hAA);
		send_item(OP_BYTE, CHAR_LF);
		send_item(OP_BYTE, 8'h41);
		send_item(OP_UNUSED, 8'hFF);            // ignored request mid-line
		send_item(OP_BYTE, CHAR_LF);
		send_item(OP_BYTE, 8'h42);
		clock_ms = 32'hFFFF_FFFF;
		send_item(OP_POLL, 8'h00);              // timeout disabled
		send_item(OP_LINKERR, 8'h00);           // discards partial line
		send_item(OP_LINKERR, 8'hFF);           // reported on empty line too
		clock_ms = '0;
		settle_results();
	endtask

	task automatic test_line_limits();
		send_filler(LINE_BYTES - 1);
		send_item(OP_BYTE, CHAR_LF);            // longest line
		send_filler(LINE_BYTES);                // last byte overflows
		send_item(OP_BYTE, CHAR_LF);
		settle_results();
	endtask

	task automatic test_capacity();
		write_register(ADDR_CAPACITY, 32'd1);
		send_filler(1);
		send_item(OP_BYTE, CHAR_LF);
		send_item(OP_BYTE, CHAR_LF);            // empty line still fits
		settle_results();
		write_register(ADDR_CAPACITY, 32'd5);
		send_filler(4);
		send_item(OP_BYTE, CHAR_LF);
		send_filler(5);
		send_item(OP_BYTE, CHAR_LF);
		settle_results();
		write_register(ADDR_CAPACITY, 32'd65535);
		send_filler(LINE_BYTES - 1);
		send_item(OP_BYTE, CHAR_LF);
		settle_results();
		write_register(ADDR_CAPACITY, 32'(CAPACITY_RESET));
	endtask

	task automatic test_timeout();
		write_register(ADDR_TIMEOUT, 32'd1);
		clock_ms = 32'd1000;
		send_item(OP_BYTE, 8'h31);
		send_item(OP_POLL, 8'h00);
		clock_ms = 32'd1001;
		send_item(OP_POLL, 8'h00);
		send_item(OP_POLL, 8'h00);              // nothing left to discard
		settle_results();
		write_register(ADDR_TIMEOUT, 32'hFFFF_FFFF);
		clock_ms = 32'd5;
		send_item(OP_BYTE, 8'h32);
		clock_ms = 32'd3;
		send_item(OP_POLL, 8'h00);
		clock_ms = 32'd4;
		send_item(OP_POLL, 8'h00);
		settle_results();
		// elapsed time across the 32-bit wrap; start time kept from the first byte
		write_register(ADDR_TIMEOUT, 32'd100);
		clock_ms = 32'hFFFF_FFC0;
		send_item(OP_BYTE, 8'h33);
		clock_ms = 32'h20;
		send_item(OP_POLL, 8'h00);
		clock_ms = 32'h22;
		send_item(OP_BYTE, 8'h34);
		clock_ms = 32'h24;
		send_item(OP_POLL, 8'h00);
		settle_results();
	endtask

	task automatic step_clock();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			clock_ms += $urandom_range(0, 3);
		else if (r < 9)
			clock_ms += $urandom_range(0, 40);
		else
			clock_ms += $urandom;
	endtask

	task automatic send_random_line();
		int n;
		int r;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 12);
		for (int i = 0; i < n; i++) begin
			step_clock();
			r = $urandom_range(0, 19);
			if (r == 0)
				send_item(OP_POLL, 8'($urandom));
			else if (r == 1)
				send_item(OP_BYTE, CHAR_CR);
			else
				send_item(OP_BYTE, 8'($urandom_range(0, 255)));
		end
		step_clock();
		r = $urandom_range(0, 9);
		if (r == 0) begin
			send_item(OP_LINKERR, 8'($urandom));
		end else if (r == 1) begin
			clock_ms += cfg_timeout + $urandom_range(0, 3);
			send_item(OP_POLL, 8'($urandom));
		end else begin
			send_item(OP_BYTE, CHAR_LF);
		end
	endtask

	task automatic test_random_traffic();
		int start;
		for (int ph = 0; ph < PHASES; ph++) begin
			settle_results();
			case (ph)
				0: begin
					write_register(ADDR_TIMEOUT, 32'd20);
					write_register(ADDR_CAPACITY, 32'd64);
				end
				1: begin
					write_register(ADDR_TIMEOUT, 32'd0);
					write_register(ADDR_CAPACITY, 32'd65535);
				end
				2: begin
					write_register(ADDR_TIMEOUT, $urandom_range(5, 60));
					write_register(ADDR_CAPACITY, $urandom_range(1, 12));
				end
				default: begin
					write_register(ADDR_TIMEOUT, $urandom);
					write_register(ADDR_CAPACITY, $urandom_range(1, 65535));
				end
			endcase
			clock_ms = $urandom;
			start = items_sent;
			while (items_sent - start < RANDOM_ITEMS / PHASES) begin
				calm = ($urandom_range(0, 4) == 0);
				send_random_line();
				if ($urandom_range(0, 24) == 0)
					settle_results();
			end
			calm = 1'b0;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_register_defaults();
		test_line_basics();
		test_line_limits();
		test_capacity();
		test_timeout();
		test_random_traffic();
		settle_results();
		if (n_bad == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
rtl/lf_pkg.sv
rtl/lf_ram.sv
rtl/lf_fifo.sv
rtl/lf_front.sv
rtl/lf_back.sv
rtl/line_framer_with_timeout.sv
tb/tb_top.sv
